@@ src/msb_pkg.sv @@
// Shared types and constants for the merge sort batch unit.
// No dependencies; used by msb_cell and merge_sort_batch_unit.
package msb_pkg;

  localparam int DATA_W        = 32;
  localparam int MAX_ITEMS_DEF = 64;

  typedef logic signed [DATA_W-1:0] data_t;

  // value travelling down the cell row during insertion
  typedef struct packed {
    logic  valid;
    data_t value;
  } carry_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SETTLE,
    ST_EMIT
  } state_e;

endpackage

@@ src/msb_cell.sv @@
// One sorting cell: holds a single value, keeps the smaller of held and
// incoming values, forwards the larger one. Depends on msb_pkg.
module msb_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  msb_pkg::carry_t carry_i,
  output msb_pkg::carry_t carry_o,
  input  logic           shift_i,
  input  logic           nbr_full_i,
  input  msb_pkg::data_t nbr_val_i,
  output logic           full_o,
  output msb_pkg::data_t val_o
);

  logic            full_q, full_d;
  msb_pkg::data_t  val_q, val_d;
  logic            cvalid_q, cvalid_d;
  msb_pkg::data_t  cval_q, cval_d;

  always_comb begin
    full_d   = full_q;
    val_d    = val_q;
    cvalid_d = 1'b0;
    cval_d   = cval_q;
    if (shift_i) begin
      // output drain: take the right neighbor's contents
      full_d = nbr_full_i;
      val_d  = nbr_val_i;
    end else if (carry_i.valid) begin
      if (!full_q) begin
        full_d = 1'b1;
        val_d  = carry_i.value;
      end else if (carry_i.value < val_q) begin
        val_d    = carry_i.value;
        cvalid_d = 1'b1;
        cval_d   = val_q;
      end else begin
        cvalid_d = 1'b1;
        cval_d   = carry_i.value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q   <= 1'b0;
      cvalid_q <= 1'b0;
    end else begin
      full_q   <= full_d;
      cvalid_q <= cvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    cval_q <= cval_d;
  end

  assign full_o        = full_q;
  assign val_o         = val_q;
  assign carry_o.valid = cvalid_q;
  assign carry_o.value = cval_q;

endmodule

@@ src/merge_sort_batch_unit.sv @@
// Top level of the batch sorter: control, item count and the cell row.
// Depends on msb_pkg and msb_cell.

// Sorts a batch of signed 32-bit values into ascending order. Values are
// taken one per cycle while loading; each enters a row of MAX_ITEMS cells and
// ripples down it, every cell keeping the smaller value it has seen. After
// the request carrying last, input stalls while the final value settles
// through the row, then the n sorted values leave one per cycle (output
// stall permitting) from the head of the row. Values past MAX_ITEMS are
// dropped and every result of that batch carries overflow.
module merge_sort_batch_unit #(
  parameter int MAX_ITEMS = msb_pkg::MAX_ITEMS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      stall_o,
  input  logic signed [msb_pkg::DATA_W-1:0] value_i,
  input  logic                      last_i,
  output logic                      valid_o,
  input  logic                      stall_i,
  output logic signed [msb_pkg::DATA_W-1:0] sorted_value_o,
  output logic                      final_res_o,
  output logic                      overflow_o
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int SET_W = $clog2(MAX_ITEMS);

  msb_pkg::state_e   state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              ovf_q, ovf_d;
  logic [SET_W-1:0]  settle_q, settle_d;

  logic in_acc, shift, room;

  msb_pkg::carry_t   carry_w [MAX_ITEMS+1];
  logic              full_w  [MAX_ITEMS+1];
  msb_pkg::data_t    val_w   [MAX_ITEMS+1];

  assign stall_o = (state_q != msb_pkg::ST_LOAD);
  assign in_acc  = valid_i && !stall_o;
  assign room    = (count_q < CNT_W'(MAX_ITEMS));
  assign valid_o = (state_q == msb_pkg::ST_EMIT);
  assign shift   = valid_o && !stall_i;

  assign sorted_value_o = val_w[0];
  assign final_res_o    = (count_q == CNT_W'(1));
  assign overflow_o     = ovf_q;

  assign carry_w[0].valid = in_acc && room;
  assign carry_w[0].value = value_i;
  assign full_w[MAX_ITEMS] = 1'b0;
  assign val_w[MAX_ITEMS]  = '0;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    msb_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .carry_i    (carry_w[i]),
      .carry_o    (carry_w[i+1]),
      .shift_i    (shift),
      .nbr_full_i (full_w[i+1]),
      .nbr_val_i  (val_w[i+1]),
      .full_o     (full_w[i]),
      .val_o      (val_w[i])
    );
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    ovf_d    = ovf_q;
    settle_d = settle_q;
    unique case (state_q)
      msb_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (room) count_d = count_q + CNT_W'(1);
          else      ovf_d   = 1'b1;
          if (last_i) begin
            state_d  = msb_pkg::ST_SETTLE;
            settle_d = SET_W'(MAX_ITEMS - 1);
          end
        end
      end
      msb_pkg::ST_SETTLE: begin
        if (settle_q == '0) state_d = msb_pkg::ST_EMIT;
        else                settle_d = settle_q - SET_W'(1);
      end
      msb_pkg::ST_EMIT: begin
        if (shift) begin
          count_d = count_q - CNT_W'(1);
          if (final_res_o) begin
            state_d = msb_pkg::ST_LOAD;
            ovf_d   = 1'b0;
          end
        end
      end
      default: state_d = msb_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= msb_pkg::ST_LOAD;
      count_q  <= '0;
      ovf_q    <= 1'b0;
      settle_q <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ovf_q    <= ovf_d;
      settle_q <= settle_d;
    end
  end

  // the row never runs out of cells
  a_no_spill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !carry_w[MAX_ITEMS].valid)
    else $error("value pushed past the last cell");

  // head cell full and passing nothing down the row while draining
  a_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !carry_w[1].valid && full_w[0])
    else $error("emitting before the row settled");

  a_ascending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift && !final_res_o |=> valid_o && (sorted_value_o >= $past(sorted_value_o)))
    else $error("results out of order");

  a_ovf_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift && !final_res_o |=> overflow_o == $past(overflow_o))
    else $error("overflow changed within a batch");

endmodule
